// File: rtl/sbm_pkg.sv
package sbm_pkg;

  localparam int CycleBitsDefault = 32;
  localparam int StampWidth = 32;
  localparam int AddrWidth = 16;
  localparam int ByteWidth = 8;
  localparam int SelWidth = 5;
  localparam int CountWidth = 3;
  localparam int BankCountWidth = 6;
  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth = 6;

  localparam logic [CfgIndexWidth-1:0] RegBusConflict = 1'd0;
  localparam logic [CfgIndexWidth-1:0] RegPrgBankCount = 1'd1;

  localparam logic [BankCountWidth-1:0] BankCountReset = 6'd16;
  localparam logic [SelWidth-1:0] ControlReset = 5'h0C;
  localparam logic [SelWidth-1:0] PrgModeForce = 5'b01100;
  localparam logic [CountWidth-1:0] ShiftLength = 3'd5;
  localparam int FilterGap = 2;
  localparam int ResetBit = 7;

  localparam logic [1:0] TargetControl = 2'd0;
  localparam logic [1:0] TargetChrZero = 2'd1;
  localparam logic [1:0] TargetChrOne = 2'd2;
  localparam logic [1:0] TargetPrg = 2'd3;

  localparam logic [1:0] PrgModeSwitchLow = 2'd0;
  localparam logic [1:0] PrgModeSwitchHigh = 2'd1;
  localparam logic [1:0] PrgModeFixFirst = 2'd2;
  localparam logic [1:0] PrgModeFixLast = 2'd3;

  typedef struct packed {
    logic [1:0] mirroring;
    logic [SelWidth-1:0] chr_low_bank;
    logic [SelWidth-1:0] chr_high_bank;
    logic [SelWidth-1:0] prg_low_bank;
    logic [SelWidth-1:0] prg_high_bank;
    logic prg_ram_enable;
  } map_t;

endpackage

// File: rtl/sbm_decode.sv
module sbm_decode (
  input  logic [sbm_pkg::SelWidth-1:0]       control_word,
  input  logic [sbm_pkg::SelWidth-1:0]       chr_select_zero,
  input  logic [sbm_pkg::SelWidth-1:0]       chr_select_one,
  input  logic [sbm_pkg::SelWidth-1:0]       prg_select,
  input  logic [sbm_pkg::BankCountWidth-1:0] prg_bank_count,
  output sbm_pkg::map_t                      mapping
);

  logic [sbm_pkg::BankCountWidth-1:0] last_full;
  logic [sbm_pkg::SelWidth-1:0]       last_bank;
  logic [3:0]                         b;

  assign last_full = prg_bank_count - sbm_pkg::BankCountWidth'(1);
  assign last_bank = last_full[sbm_pkg::SelWidth-1:0];
  assign b = prg_select[3:0];

  always_comb begin
    mapping.mirroring = control_word[1:0];
    mapping.prg_ram_enable = ~prg_select[4];
    // 8 KB chr mode pairs an even bank with the next one
    if (control_word[4]) begin
      mapping.chr_low_bank = chr_select_zero;
      mapping.chr_high_bank = chr_select_one;
    end else begin
      mapping.chr_low_bank = {chr_select_zero[4:1], 1'b0};
      mapping.chr_high_bank = {chr_select_zero[4:1], 1'b1};
    end
    case (control_word[3:2])
      sbm_pkg::PrgModeSwitchLow, sbm_pkg::PrgModeSwitchHigh: begin
        mapping.prg_low_bank = {1'b0, b[3:1], 1'b0};
        mapping.prg_high_bank = {1'b0, b[3:1], 1'b1};
      end
      sbm_pkg::PrgModeFixFirst: begin
        mapping.prg_low_bank = '0;
        mapping.prg_high_bank = {1'b0, b};
      end
      sbm_pkg::PrgModeFixLast: begin
        mapping.prg_low_bank = {1'b0, b};
        mapping.prg_high_bank = last_bank;
      end
      default: begin
        mapping.prg_low_bank = {1'b0, b};
        mapping.prg_high_bank = last_bank;
      end
    endcase
  end

endmodule

// File: rtl/serial_bank_mapper.sv
// Serial-load cartridge bank mapper. Each transaction on the item channel is
// one CPU write and yields exactly one transaction on the result channel with
// the mapping in force after that write, and accepted low when its cycle stamp
// is no later than the last accepted write's stamp plus FilterGap. One item is
// accepted every clock while item_stall is low; a result passes through the
// input register, then the state update and bank decode into the result
// register. The item channel stalls only while both registers are full and the
// result is stalled. Configuration writes are meant for an idle block.
module serial_bank_mapper #(
  parameter int CYCLE_BITS = sbm_pkg::CycleBitsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [sbm_pkg::AddrWidth-1:0]        cpu_address,
  input  logic [sbm_pkg::ByteWidth-1:0]        write_value,
  input  logic [sbm_pkg::ByteWidth-1:0]        rom_byte,
  input  logic [sbm_pkg::StampWidth-1:0]       cycle_stamp,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 accepted,
  output logic [1:0]                           mirroring,
  output logic [sbm_pkg::SelWidth-1:0]         chr_low_bank,
  output logic [sbm_pkg::SelWidth-1:0]         chr_high_bank,
  output logic [sbm_pkg::SelWidth-1:0]         prg_low_bank,
  output logic [sbm_pkg::SelWidth-1:0]         prg_high_bank,
  output logic                                 prg_ram_enable,
  input  logic                                 cfg_write,
  input  logic [sbm_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [sbm_pkg::CfgDataWidth-1:0]     cfg_data
);

  localparam int CycUsed = (CYCLE_BITS < sbm_pkg::StampWidth) ? CYCLE_BITS
                                                              : sbm_pkg::StampWidth;

  // configuration
  logic                                 bus_conflict_enable;
  logic [sbm_pkg::BankCountWidth-1:0]   prg_bank_count;

  // input register
  logic                                 s1_valid;
  logic [1:0]                           s1_target;
  logic                                 s1_clear;
  logic                                 s1_bit;
  logic [CycUsed-1:0]                   s1_cycle;

  // mapper state
  logic [sbm_pkg::SelWidth-1:0]         shift_value, shift_value_next;
  logic [sbm_pkg::CountWidth-1:0]       bits_shifted, bits_shifted_next;
  logic [sbm_pkg::SelWidth-1:0]         control_word, control_word_next;
  logic [sbm_pkg::SelWidth-1:0]         chr_select_zero, chr_select_zero_next;
  logic [sbm_pkg::SelWidth-1:0]         chr_select_one, chr_select_one_next;
  logic [sbm_pkg::SelWidth-1:0]         prg_select, prg_select_next;
  logic [CYCLE_BITS-1:0]                last_accept_cycle;

  // result register
  logic                                 res_accepted;
  sbm_pkg::map_t                        res_map;
  sbm_pkg::map_t                        map_next;

  logic                                 advance;
  logic                                 take;
  logic [sbm_pkg::ByteWidth-1:0]        val;
  logic [CycUsed:0]                     window_end;
  logic                                 too_close;
  logic [sbm_pkg::SelWidth-1:0]         shifted;
  logic [sbm_pkg::CountWidth-1:0]       count_inc;

  assign advance = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && result_valid && result_stall;
  assign take = item_valid && !item_stall;

  assign val = bus_conflict_enable ? (write_value & rom_byte) : write_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_conflict_enable <= 1'b0;
      prg_bank_count <= sbm_pkg::BankCountReset;
    end else if (cfg_write) begin
      case (cfg_index)
        sbm_pkg::RegBusConflict: bus_conflict_enable <= cfg_data[0];
        sbm_pkg::RegPrgBankCount: prg_bank_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_target <= cpu_address[14:13];
      s1_clear <= val[sbm_pkg::ResetBit];
      s1_bit <= val[0];
      s1_cycle <= cycle_stamp[CycUsed-1:0];
    end
  end

  // no wrap: the window end keeps its carry
  assign window_end = {1'b0, last_accept_cycle[CycUsed-1:0]} + (CycUsed+1)'(sbm_pkg::FilterGap);
  assign too_close = {1'b0, s1_cycle} <= window_end;

  assign shifted = {s1_bit, shift_value[sbm_pkg::SelWidth-1:1]};
  assign count_inc = bits_shifted + sbm_pkg::CountWidth'(1);

  always_comb begin
    shift_value_next = shift_value;
    bits_shifted_next = bits_shifted;
    control_word_next = control_word;
    chr_select_zero_next = chr_select_zero;
    chr_select_one_next = chr_select_one;
    prg_select_next = prg_select;
    if (!too_close) begin
      if (s1_clear) begin
        shift_value_next = '0;
        bits_shifted_next = '0;
        control_word_next = control_word | sbm_pkg::PrgModeForce;
      end else if (count_inc == sbm_pkg::ShiftLength) begin
        shift_value_next = '0;
        bits_shifted_next = '0;
        case (s1_target)
          sbm_pkg::TargetControl: control_word_next = shifted;
          sbm_pkg::TargetChrZero: chr_select_zero_next = shifted;
          sbm_pkg::TargetChrOne: chr_select_one_next = shifted;
          sbm_pkg::TargetPrg: prg_select_next = shifted;
          default: prg_select_next = shifted;
        endcase
      end else begin
        shift_value_next = shifted;
        bits_shifted_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value <= '0;
      bits_shifted <= '0;
      control_word <= sbm_pkg::ControlReset;
      chr_select_zero <= '0;
      chr_select_one <= '0;
      prg_select <= '0;
      last_accept_cycle <= '0;
    end else if (advance) begin
      shift_value <= shift_value_next;
      bits_shifted <= bits_shifted_next;
      control_word <= control_word_next;
      chr_select_zero <= chr_select_zero_next;
      chr_select_one <= chr_select_one_next;
      prg_select <= prg_select_next;
      if (!too_close) begin
        last_accept_cycle <= CYCLE_BITS'(s1_cycle);
      end
    end
  end

  sbm_decode u_decode (
    .control_word    (control_word_next),
    .chr_select_zero (chr_select_zero_next),
    .chr_select_one  (chr_select_one_next),
    .prg_select      (prg_select_next),
    .prg_bank_count  (prg_bank_count),
    .mapping         (map_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_accepted <= !too_close;
      res_map <= map_next;
    end
  end

  assign accepted = res_accepted;
  assign mirroring = res_map.mirroring;
  assign chr_low_bank = res_map.chr_low_bank;
  assign chr_high_bank = res_map.chr_high_bank;
  assign prg_low_bank = res_map.prg_low_bank;
  assign prg_high_bank = res_map.prg_high_bank;
  assign prg_ram_enable = res_map.prg_ram_enable;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bits_shifted < sbm_pkg::ShiftLength)
    else $error("serial count out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid))
    else $error("item stall without full pipeline");

  a_filtered_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && too_close) |=> ($stable(control_word) && $stable(prg_select)
      && $stable(shift_value) && $stable(last_accept_cycle) && !res_accepted))
    else $error("filtered transaction changed state");

  a_clear_forces_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && !too_close && s1_clear) |=>
      (control_word[3:2] == sbm_pkg::PrgModeFixLast && bits_shifted == '0))
    else $error("reset write did not force prg mode");

  a_stamp_taken: assert property (@(posedge clk) disable iff (rst)
    (advance && !too_close) |=>
      (last_accept_cycle == CYCLE_BITS'($past(s1_cycle)) && res_accepted))
    else $error("accepted stamp not recorded");
`endif

endmodule
